// File: rtl/fvnb_pkg.sv
// Package for the fractal value noise unit with bicubic interpolation.
// Holds the shared widths, hash constants, defaults and configuration types.
// No dependencies.
package fvnb_pkg;

    localparam int MAX_OCTAVES_DEF   = 8;
    localparam int OCTAVE_OFFSET_DEF = 4096;

    localparam int FRAC_W  = 16;
    localparam int COORD_W = 32;
    localparam int FREQ_W  = 24;
    localparam int PERS_W  = 16;
    localparam int SEED_W  = 16;
    localparam int COUNT_W = 4;
    localparam int PX_W    = COORD_W + FREQ_W + 1;
    localparam int SX_W    = PX_W + 1;
    localparam int AMP_W   = FRAC_W + 1;
    localparam int SUM_W   = 32;
    localparam int LAT_W   = 18;
    localparam int ROW_W   = LAT_W + 5;
    localparam int OCT_W   = ROW_W + 5;
    localparam int HEIGHT_W = 24;
    localparam int CFG_W   = 24;
    localparam int CELL_LAT = 16;

    localparam logic [31:0] HASH_Y_MUL = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_MUL   = 32'd15731;
    localparam logic [31:0] HASH_ADD1  = 32'd789221;
    localparam logic [31:0] HASH_ADD2  = 32'd1376312589;

    typedef enum logic [1:0] {
        REG_OCTAVE_COUNT,
        REG_BASE_FREQUENCY,
        REG_PERSISTENCE,
        REG_NOISE_SEED
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] octave_count;
        logic [FREQ_W-1:0]  base_frequency;
        logic [PERS_W-1:0]  persistence;
        logic [SEED_W-1:0]  noise_seed;
    } cfg_t;

endpackage

// File: rtl/fractal_value_noise_bicubic_unit.sv
// Top level of the fractal value noise unit: input scaling, octave cell chain,
// output normalization and the configuration registers.
// Depends on fvnb_pkg and fvnb_cell.
//
// Usage: points enter on the s_ stream channel (x_coord, y_coord in Q16.16),
// heights leave on the m_ stream channel (Q8.16, saturated). Each accepted
// transaction yields exactly one result transaction, in order.
// The datapath is one pipeline: a scaling multiply stage, a chain of
// MAX_OCTAVES octave cells of 16 stages each, and an output register. A new
// point is accepted in every cycle unless the receiver stalls, so throughput
// is one point per cycle while the output is not stalled.
// When the receiver stalls with a result waiting in the output register the
// whole pipeline holds and s_tready falls; no result is lost.
// Configuration registers are written through the cfg_ channel, which is always
// ready; they must only change while no points are in flight.
// Reset clears all valid flags and loads the default configuration.
module fractal_value_noise_bicubic_unit #(
    parameter int MAX_OCTAVES   = fvnb_pkg::MAX_OCTAVES_DEF,
    parameter int OCTAVE_OFFSET = fvnb_pkg::OCTAVE_OFFSET_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // x_coord, y_coord
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fvnb_pkg::HEIGHT_W-1:0]     m_tdata,   // height
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [fvnb_pkg::CFG_W-1:0]        cfg_data
);
    import fvnb_pkg::*;

    localparam int VL = 1 + CELL_LAT * MAX_OCTAVES;

    cfg_t cfg_reg;
    logic en;
    logic [VL-1:0] vld_reg;
    logic m_tvalid_reg;
    logic [HEIGHT_W-1:0] m_tdata_reg, height_next;
    logic signed [PX_W-1:0] px_reg, py_reg;
    logic signed [PX_W-1:0] px_c [MAX_OCTAVES+1];
    logic signed [PX_W-1:0] py_c [MAX_OCTAVES+1];
    logic [AMP_W-1:0] amp_c [MAX_OCTAVES+1];
    logic signed [SUM_W-1:0] sum_c [MAX_OCTAVES+1];
    logic signed [SUM_W:0] hsum;
    logic signed [SUM_W-1:0] hval;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.octave_count   <= COUNT_W'(4);
            cfg_reg.base_frequency <= FREQ_W'(65536);
            cfg_reg.persistence    <= PERS_W'(32768);
            cfg_reg.noise_seed     <= SEED_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OCTAVE_COUNT:   cfg_reg.octave_count   <= cfg_data[COUNT_W-1:0];
                REG_BASE_FREQUENCY: cfg_reg.base_frequency <= cfg_data[FREQ_W-1:0];
                REG_PERSISTENCE:    cfg_reg.persistence    <= cfg_data[PERS_W-1:0];
                REG_NOISE_SEED:     cfg_reg.noise_seed     <= cfg_data[SEED_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[VL-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[VL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= PX_W'($signed(s_tdata[31:0])) *
                      PX_W'($signed({1'b0, cfg_reg.base_frequency}));
            py_reg <= PX_W'($signed(s_tdata[63:32])) *
                      PX_W'($signed({1'b0, cfg_reg.base_frequency}));
            m_tdata_reg <= height_next;
        end
    end

    assign px_c[0]  = px_reg;
    assign py_c[0]  = py_reg;
    assign amp_c[0] = AMP_W'(65536);
    assign sum_c[0] = '0;

    for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_cell
        fvnb_cell #(.IDX(gi), .OCTAVE_OFFSET(OCTAVE_OFFSET)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .cfg     (cfg_reg),
            .px_in   (px_c[gi]),
            .py_in   (py_c[gi]),
            .amp_in  (amp_c[gi]),
            .sum_in  (sum_c[gi]),
            .px_out  (px_c[gi+1]),
            .py_out  (py_c[gi+1]),
            .amp_out (amp_c[gi+1]),
            .sum_out (sum_c[gi+1])
        );
    end

    always_comb begin
        hsum = (SUM_W+1)'(sum_c[MAX_OCTAVES]) + (SUM_W+1)'(65536);
        hval = SUM_W'(hsum >>> 1);
        if (hval > SUM_W'(8388607)) begin
            height_next = HEIGHT_W'(8388607);
        end else if (hval < -SUM_W'(8388608)) begin
            height_next = HEIGHT_W'(-SUM_W'(8388608));
        end else begin
            height_next = hval[HEIGHT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/fvnb_lattice.sv
// Four-stage pipelined lattice hash producing one Q2.16 lattice value.
// Depends on fvnb_pkg.
module fvnb_lattice #(
    parameter int DX = 0,
    parameter int DY = 0
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [31:0]                    ix,
    input  logic [31:0]                    iy,
    input  logic [fvnb_pkg::SEED_W-1:0]    seed,
    output logic signed [fvnb_pkg::LAT_W-1:0] value
);
    import fvnb_pkg::*;

    logic [31:0] xw, yw, n, n2_next;
    logic [31:0] n2_s1_reg, n2_s2_reg, n2_s3_reg;
    logic [31:0] a_s2_reg, b_s3_reg, a_next, b_next, c_next;
    logic signed [LAT_W-1:0] value_reg, value_next;

    always_comb begin
        xw = ix + 32'(DX);
        yw = iy + 32'(DY);
        n = xw + yw * HASH_Y_MUL + {{(32-SEED_W){1'b0}}, seed};
        n2_next = (n << HASH_SHIFT) ^ n;
        a_next = n2_s1_reg * n2_s1_reg;
        b_next = a_s2_reg * HASH_MUL + HASH_ADD1;
        c_next = n2_s3_reg * b_s3_reg + HASH_ADD2;
        value_next = LAT_W'(65536) - $signed({1'b0, c_next[30:14]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_s1_reg <= n2_next;
            a_s2_reg  <= a_next;
            n2_s2_reg <= n2_s1_reg;
            b_s3_reg  <= b_next;
            n2_s3_reg <= n2_s2_reg;
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// File: rtl/fvnb_cubic.sv
// Four-stage pipelined Catmull-Rom cubic evaluated by Horner's rule.
// Depends on fvnb_pkg.
module fvnb_cubic #(
    parameter int IW = 18
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [IW-1:0]             a,
    input  logic signed [IW-1:0]             b,
    input  logic signed [IW-1:0]             c,
    input  logic signed [IW-1:0]             d,
    input  logic signed [fvnb_pkg::FRAC_W:0] t,
    output logic signed [IW+4:0]             r
);
    import fvnb_pkg::*;

    localparam int HW = IW + 5;
    localparam int PW = HW + FRAC_W + 1;

    logic signed [HW-1:0] ae, be, ce, de;
    logic signed [HW-1:0] d3_next, d2_next, d1_next;
    logic signed [HW-1:0] d3_s1_reg, d2_s1_reg, d1_s1_reg, b_s1_reg;
    logic signed [HW-1:0] h_s2_reg, d1_s2_reg, b_s2_reg;
    logic signed [HW-1:0] h_s3_reg, b_s3_reg, r_reg;
    logic signed [FRAC_W:0] t_s1_reg, t_s2_reg, t_s3_reg;
    logic signed [PW-1:0] p2, p3, p4;
    logic signed [HW-1:0] h2_next, h3_next, h4, r_next;

    always_comb begin
        ae = HW'(a);
        be = HW'(b);
        ce = HW'(c);
        de = HW'(d);
        d3_next = de - ae + (be <<< 1) + be - (ce <<< 1) - ce;
        d2_next = (ae <<< 1) - (be <<< 2) - be + (ce <<< 2) - de;
        d1_next = ce - ae;
        p2 = PW'(d3_s1_reg) * PW'(t_s1_reg);
        h2_next = HW'(p2 >>> FRAC_W) + d2_s1_reg;
        p3 = PW'(h_s2_reg) * PW'(t_s2_reg);
        h3_next = HW'(p3 >>> FRAC_W) + d1_s2_reg;
        p4 = PW'(h_s3_reg) * PW'(t_s3_reg);
        h4 = HW'(p4 >>> FRAC_W);
        r_next = b_s3_reg + (h4 >>> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d3_s1_reg <= d3_next;
            d2_s1_reg <= d2_next;
            d1_s1_reg <= d1_next;
            b_s1_reg  <= be;
            t_s1_reg  <= t;
            h_s2_reg  <= h2_next;
            d1_s2_reg <= d1_s1_reg;
            b_s2_reg  <= b_s1_reg;
            t_s2_reg  <= t_s1_reg;
            h_s3_reg  <= h3_next;
            b_s3_reg  <= b_s2_reg;
            t_s3_reg  <= t_s2_reg;
            r_reg     <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// File: rtl/fvnb_cell.sv
// One octave cell of the chain: scales the point, hashes the 4x4 lattice,
// interpolates bicubically and accumulates the weighted result.
// Depends on fvnb_pkg, fvnb_lattice and fvnb_cubic.
module fvnb_cell #(
    parameter int IDX           = 0,
    parameter int OCTAVE_OFFSET = fvnb_pkg::OCTAVE_OFFSET_DEF
) (
    input  logic                                aclk,
    input  logic                                en,
    input  fvnb_pkg::cfg_t                      cfg,
    input  logic signed [fvnb_pkg::PX_W-1:0]    px_in,
    input  logic signed [fvnb_pkg::PX_W-1:0]    py_in,
    input  logic [fvnb_pkg::AMP_W-1:0]          amp_in,
    input  logic signed [fvnb_pkg::SUM_W-1:0]   sum_in,
    output logic signed [fvnb_pkg::PX_W-1:0]    px_out,
    output logic signed [fvnb_pkg::PX_W-1:0]    py_out,
    output logic [fvnb_pkg::AMP_W-1:0]          amp_out,
    output logic signed [fvnb_pkg::SUM_W-1:0]   sum_out
);
    import fvnb_pkg::*;

    localparam int    SH  = FRAC_W - IDX;
    localparam longint OFF = longint'(IDX) * longint'(OCTAVE_OFFSET) * 64'sd65536;

    logic signed [SX_W-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic signed [SX_W-1:0] magx, magy;
    logic negx, negy;
    logic [31:0] ix_reg, iy_reg, ix_next, iy_next;
    logic signed [FRAC_W:0] fx_reg, fy_reg, fx_next, fy_next;
    logic signed [FRAC_W:0] fx_dly_reg [4];
    logic signed [FRAC_W:0] fy_dly_reg [8];
    logic signed [PX_W-1:0] px_dly_reg [CELL_LAT];
    logic signed [PX_W-1:0] py_dly_reg [CELL_LAT];
    logic [AMP_W-1:0]       amp_dly_reg [CELL_LAT-2];
    logic signed [SUM_W-1:0] sum_dly_reg [CELL_LAT-1];
    logic signed [LAT_W-1:0] lat_val [4][4];
    logic signed [ROW_W-1:0] row_val [4];
    logic signed [OCT_W-1:0] oct_val;
    logic signed [OCT_W+AMP_W:0] wprod;
    logic [AMP_W+PERS_W-1:0] aprod;
    logic signed [SUM_W-1:0] w_reg, w_next, sum_out_reg;
    logic [AMP_W-1:0] ampn_reg, amp_out_reg;
    logic active;

    always_comb begin
        sx_next = SX_W'(px_in >>> SH) + SX_W'(OFF);
        sy_next = SX_W'(py_in >>> SH) + SX_W'(OFF);
        negx = sx_reg[SX_W-1];
        negy = sy_reg[SX_W-1];
        magx = negx ? -sx_reg : sx_reg;
        magy = negy ? -sy_reg : sy_reg;
        ix_next = negx ? -magx[FRAC_W+31:FRAC_W] : magx[FRAC_W+31:FRAC_W];
        iy_next = negy ? -magy[FRAC_W+31:FRAC_W] : magy[FRAC_W+31:FRAC_W];
        fx_next = negx ? -$signed({1'b0, magx[FRAC_W-1:0]}) : $signed({1'b0, magx[FRAC_W-1:0]});
        fy_next = negy ? -$signed({1'b0, magy[FRAC_W-1:0]}) : $signed({1'b0, magy[FRAC_W-1:0]});
        active = cfg.octave_count > COUNT_W'(IDX);
        wprod = (OCT_W+AMP_W+1)'(oct_val) *
                (OCT_W+AMP_W+1)'($signed({1'b0, amp_dly_reg[CELL_LAT-3]}));
        w_next = active ? SUM_W'(wprod >>> FRAC_W) : '0;
        aprod = amp_dly_reg[CELL_LAT-3] * cfg.persistence;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            ix_reg <= ix_next;
            iy_reg <= iy_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            fx_dly_reg[0] <= fx_reg;
            for (int k = 1; k < 4; k++) fx_dly_reg[k] <= fx_dly_reg[k-1];
            fy_dly_reg[0] <= fy_reg;
            for (int k = 1; k < 8; k++) fy_dly_reg[k] <= fy_dly_reg[k-1];
            px_dly_reg[0] <= px_in;
            py_dly_reg[0] <= py_in;
            for (int k = 1; k < CELL_LAT; k++) begin
                px_dly_reg[k] <= px_dly_reg[k-1];
                py_dly_reg[k] <= py_dly_reg[k-1];
            end
            amp_dly_reg[0] <= amp_in;
            for (int k = 1; k < CELL_LAT-2; k++) amp_dly_reg[k] <= amp_dly_reg[k-1];
            sum_dly_reg[0] <= sum_in;
            for (int k = 1; k < CELL_LAT-1; k++) sum_dly_reg[k] <= sum_dly_reg[k-1];
            w_reg       <= w_next;
            ampn_reg    <= AMP_W'(aprod >> FRAC_W);
            sum_out_reg <= sum_dly_reg[CELL_LAT-2] + w_reg;
            amp_out_reg <= ampn_reg;
        end
    end

    for (genvar gy = 0; gy < 4; gy++) begin : g_row
        for (genvar gx = 0; gx < 4; gx++) begin : g_col
            fvnb_lattice #(.DX(gx - 1), .DY(gy - 1)) u_lattice (
                .aclk  (aclk),
                .en    (en),
                .ix    (ix_reg),
                .iy    (iy_reg),
                .seed  (cfg.noise_seed),
                .value (lat_val[gy][gx])
            );
        end
        fvnb_cubic #(.IW(LAT_W)) u_row (
            .aclk (aclk),
            .en   (en),
            .a    (lat_val[gy][0]),
            .b    (lat_val[gy][1]),
            .c    (lat_val[gy][2]),
            .d    (lat_val[gy][3]),
            .t    (fx_dly_reg[3]),
            .r    (row_val[gy])
        );
    end

    fvnb_cubic #(.IW(ROW_W)) u_col (
        .aclk (aclk),
        .en   (en),
        .a    (row_val[0]),
        .b    (row_val[1]),
        .c    (row_val[2]),
        .d    (row_val[3]),
        .t    (fy_dly_reg[7]),
        .r    (oct_val)
    );

    assign px_out  = px_dly_reg[CELL_LAT-1];
    assign py_out  = py_dly_reg[CELL_LAT-1];
    assign amp_out = amp_out_reg;
    assign sum_out = sum_out_reg;

endmodule

// File: dv/tb_fractal_value_noise_bicubic_unit.sv
// Self-checking testbench for fractal_value_noise_bicubic_unit.
// Predicts each height with a fixed-point noise model and checks the m_ stream in order.
// Depends on fvnb_pkg and the unit's RTL.
module tb_fractal_value_noise_bicubic_unit;
    import fvnb_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [HEIGHT_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fractal_value_noise_bicubic_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int DRAIN_CYCLES = 2 + 16 * MAX_OCTAVES_DEF + 20;

    logic [COUNT_W-1:0] octaves_q;
    logic [FREQ_W-1:0]  freq_q;
    logic [PERS_W-1:0]  pers_q;
    logic [SEED_W-1:0]  seed_q;

    logic [HEIGHT_W-1:0] height_queue[$];
    int errors;
    int points_sent;
    int heights_seen;
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("tb_fractal_value_noise_bicubic_unit failed");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint lattice_value(bit [31:0] x, bit [31:0] y);
        bit [31:0] n;
        bit [31:0] m;
        n = x + y * 32'd57 + 32'(seed_q);
        n = (n << 13) ^ n;
        m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
        return 64'sd65536 - longint'(m >> 14);
    endfunction

    function automatic longint catmull_rom(longint a, longint b, longint c, longint d,
                                           longint t);
        longint c3;
        longint c2;
        longint c1;
        longint h;
        c3 = -a + 3 * b - 3 * c + d;
        c2 = 2 * a - 5 * b + 4 * c - d;
        c1 = c - a;
        h = floor_shift(c3 * t, 16) + c2;
        h = floor_shift(h * t, 16) + c1;
        h = floor_shift(h * t, 16);
        return b + floor_shift(h, 1);
    endfunction

    function automatic longint lattice_row(bit [31:0] ix, bit [31:0] iy, longint fx);
        return catmull_rom(lattice_value(ix - 1, iy), lattice_value(ix, iy),
                           lattice_value(ix + 1, iy), lattice_value(ix + 2, iy), fx);
    endfunction

    function automatic longint bicubic_at(longint sx, longint sy);
        longint wx;
        longint wy;
        bit [31:0] ix;
        bit [31:0] iy;
        wx = (sx >= 0) ? (sx >>> 16) : -((-sx) >>> 16);
        wy = (sy >= 0) ? (sy >>> 16) : -((-sy) >>> 16);
        ix = wx[31:0];
        iy = wy[31:0];
        return catmull_rom(lattice_row(ix, iy - 1, sx - wx * 65536),
                           lattice_row(ix, iy, sx - wx * 65536),
                           lattice_row(ix, iy + 1, sx - wx * 65536),
                           lattice_row(ix, iy + 2, sx - wx * 65536),
                           sy - wy * 65536);
    endfunction

    function automatic logic [HEIGHT_W-1:0] noise_height(logic [31:0] xc, logic [31:0] yc);
        longint px;
        longint py;
        longint amp;
        longint sum;
        longint h;
        longint off;
        int n;
        px = longint'(signed'(xc)) * longint'({1'b0, freq_q});
        py = longint'(signed'(yc)) * longint'({1'b0, freq_q});
        amp = 65536;
        sum = 0;
        n = (octaves_q > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : int'(octaves_q);
        for (int i = 0; i < n; i++) begin
            off = longint'(i) * OCTAVE_OFFSET_DEF * 65536;
            sum += floor_shift(bicubic_at(floor_shift(px, 16 - i) + off,
                                          floor_shift(py, 16 - i) + off) * amp, 16);
            amp = (amp * longint'(pers_q)) >>> 16;
        end
        h = floor_shift(sum + 65536, 1);
        if (h > 8388607) h = 8388607;
        if (h < -8388608) h = -8388608;
        return h[HEIGHT_W-1:0];
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (height_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_OCTAVE_COUNT:   octaves_q = value[COUNT_W-1:0];
            REG_BASE_FREQUENCY: freq_q    = value[FREQ_W-1:0];
            REG_PERSISTENCE:    pers_q    = value[PERS_W-1:0];
            REG_NOISE_SEED:     seed_q    = value[SEED_W-1:0];
        endcase
    endtask

    task automatic configure(int oc, int freq, int pers, int seed);
        wait_drained();
        write_reg(REG_OCTAVE_COUNT, CFG_W'(oc));
        write_reg(REG_BASE_FREQUENCY, CFG_W'(freq));
        write_reg(REG_PERSISTENCE, CFG_W'(pers));
        write_reg(REG_NOISE_SEED, CFG_W'(seed));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] xc, logic [31:0] yc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yc, xc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        height_queue.push_back(noise_height(xc, yc));
        points_sent++;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16 | $urandom_range(65535);
            2: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                              : 32'h80000000 + $urandom_range(3);
        endcase
    endfunction

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                heights_seen++;
                if (height_queue.size() == 0) begin
                    $error("height: unexpected transaction, actual %0d", $signed(m_tdata));
                    errors++;
                end else begin
                    logic [HEIGHT_W-1:0] want;
                    want = height_queue.pop_front();
                    if (want !== m_tdata) begin
                        $error("height: expected %0d actual %0d", $signed(want),
                               $signed(m_tdata));
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        configure(4, 65536, 32768, 1);
        send_point(0, 0);
        send_point(32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'h80000000, 32'h7fffffff);
        send_point(32'hffffffff, 32'h00000001);
        send_point(32'hffff8000, 32'h00018000);
        send_point(32'h0000ffff, 32'hffff0001);
        configure(0, 65536, 32768, 1);
        send_point(32'h12345678, 32'h9abcdef0);
        configure(15, 24'hffffff, 16'hffff, 16'hffff);
        send_point(32'h7fffffff, 32'h80000000);
        send_point(32'h00010000, 32'hfffe0000);
        configure(9, 0, 0, 0);
        send_point(32'h55555555, 32'haaaaaaaa);
        configure(8, 24'h800000, 16'hffff, 16'h1234);
        send_point(32'h7fff0000, 32'h80010000);
        send_point(32'hdeadbeef, 32'h0badf00d);
        configure(1, 24'h000001, 0, 0);
        send_point(32'h80000000, 32'h7fffffff);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 129 == 0)
                configure($urandom_range(15), $urandom_range(3) == 0 ? $urandom :
                          $urandom_range(262144), $urandom_range(65535), $urandom);
            if (i == count / 2) wait_drained();
            send_point(random_coord(), random_coord());
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_OCTAVE_COUNT;
        cfg_data  = '0;
        errors = 0;
        points_sent = 0;
        heights_seen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        octaves_q = 4;
        freq_q = 65536;
        pers_q = 32768;
        seed_q = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 21;
        recv_idle_pct = 86;
        test_random(510);
        send_idle_pct = 86;
        recv_idle_pct = 21;
        test_random(510);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(510);
        wait_drained();
        $display("Covered %0d points and %0d heights across directed extremes and random",
                 points_sent, heights_seen);
        $display("configurations, with sender and receiver stalls in both orders.");
        if (errors == 0) begin
            $display("tb_fractal_value_noise_bicubic_unit passed");
        end else begin
            $display("tb_fractal_value_noise_bicubic_unit failed");
        end
        $finish;
    end
endmodule
